/* hdl/tcrt_pkg.sv */
// Package for the three-channel reload timer: transaction types, register
// map codes, control-register bit positions and the prescaler divide table.
// No dependencies; used by three_channel_reload_timer.
package tcrt_pkg;

  // Default sizes handed to the top level
  localparam int NUM_CHANNELS_DEF = 3;
  localparam int COUNT_WIDTH_DEF  = 32;

  // Channels visible in the start register and in the per-channel result bits
  localparam int VIS_CHANNELS = 3;

  // Transaction kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Register map (fixed part; per-channel banks follow the control base)
  localparam logic [3:0] REG_OUTCTL    = 4'd0;
  localparam logic [3:0] REG_START     = 4'd1;
  localparam int         REG_CTRL_BASE = 2;

  // Control register bit positions
  localparam int CTRL_WIDTH = 16;
  localparam int SEL_LSB    = 0;
  localparam int SEL_MSB    = 2;
  localparam int UNIE_POS   = 5;
  localparam int UNF_POS    = 8;
  localparam int ICPF_POS   = 9;

  localparam int ACC_WIDTH = 10;
  localparam int DIV_WIDTH = ACC_WIDTH + 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  reg_select;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  irq_lines;
    logic [2:0]  underflow_pulse;
  } rsp_t;

  // Prescaler divide-by value for a select code; zero means the channel does not count
  function automatic logic [DIV_WIDTH-1:0] divide_by(input logic [2:0] sel);
    logic [DIV_WIDTH-1:0] d;
    case (sel)
      3'd0:    d = DIV_WIDTH'(4);
      3'd1:    d = DIV_WIDTH'(16);
      3'd2:    d = DIV_WIDTH'(64);
      3'd3:    d = DIV_WIDTH'(256);
      3'd4:    d = DIV_WIDTH'(1024);
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

/* hdl/three_channel_reload_timer.sv */
// Each result is registered in the result register when its transaction is taken.
// Throughput: one transaction per cycle; the request side stalls only while a
// finished result waits on a stalled response side.
// Reset (synchronous, active high): all channels stopped, control, count, reload
// and prescaler registers cleared, result register empty.
// Holds the whole timer datapath; depends on tcrt_pkg.
module three_channel_reload_timer #(
  parameter int NUM_CHANNELS = tcrt_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = tcrt_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tcrt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tcrt_pkg::rsp_t rsp
);
  import tcrt_pkg::*;

  localparam int OUT_CH         = (NUM_CHANNELS < VIS_CHANNELS) ? NUM_CHANNELS : VIS_CHANNELS;
  localparam int REG_COUNT_BASE = REG_CTRL_BASE + NUM_CHANNELS;
  localparam int REG_RELOAD_BASE = REG_CTRL_BASE + 2 * NUM_CHANNELS;

  logic [NUM_CHANNELS-1:0]    start, start_next;
  logic [CTRL_WIDTH-1:0]      ctrl       [NUM_CHANNELS];
  logic [CTRL_WIDTH-1:0]      ctrl_next  [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]     count      [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]     count_next [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]     reload     [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]     reload_next[NUM_CHANNELS];
  logic [ACC_WIDTH-1:0]       acc        [NUM_CHANNELS];
  logic [ACC_WIDTH-1:0]       acc_next   [NUM_CHANNELS];
  rsp_t                       rsp_next;
  logic                       req_fire;

  // Take a new transaction whenever the result register is free or being emptied
  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;

  // Compute next state and the result of the current transaction
  always_comb begin
    logic [DIV_WIDTH-1:0]  div;
    logic [CTRL_WIDTH-1:0] wctrl;
    logic [NUM_CHANNELS-1:0] pulse;
    logic [31:0]           rd;

    start_next = start;
    pulse      = '0;
    rd         = '0;
    div        = '0;
    wctrl      = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      ctrl_next[c]   = ctrl[c];
      count_next[c]  = count[c];
      reload_next[c] = reload[c];
      acc_next[c]    = acc[c];
    end

    case (req.kind)
      KIND_TICK: begin
        // Advance every started channel with a counting select; wrap the prescaler and decrement or reload
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          div = divide_by(ctrl[c][SEL_MSB:SEL_LSB]);
          if (start[c] && div != '0) begin
            if ({1'b0, acc[c]} + DIV_WIDTH'(1) >= div) begin
              acc_next[c] = '0;
              if (count[c] == '0) begin
                count_next[c]         = reload[c];
                ctrl_next[c][UNF_POS] = 1'b1;
                pulse[c]              = 1'b1;
              end else begin
                count_next[c] = count[c] - COUNT_WIDTH'(1);
              end
            end else begin
              acc_next[c] = acc[c] + ACC_WIDTH'(1);
            end
          end
        end
      end
      KIND_READ: begin
        if (req.reg_select == REG_OUTCTL) begin
          rd = 32'd1;
        end else if (req.reg_select == REG_START) begin
          rd = 32'(start);
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (32'(req.reg_select) == 32'(REG_CTRL_BASE + c)) rd = 32'(ctrl[c]);
          if (32'(req.reg_select) == 32'(REG_COUNT_BASE + c)) rd = 32'(count[c]);
          if (32'(req.reg_select) == 32'(REG_RELOAD_BASE + c)) rd = 32'(reload[c]);
        end
      end
      KIND_WRITE: begin
        if (req.reg_select == REG_START) begin
          // Only the visible channels can be started; a changed bit clears its prescaler
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            start_next[c] = (c < VIS_CHANNELS) ? req.write_data[c] : 1'b0;
            if (start_next[c] != start[c]) acc_next[c] = '0;
          end
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (32'(req.reg_select) == 32'(REG_CTRL_BASE + c)) begin
            // Flags can only be cleared; a new prescaler select clears the prescaler
            wctrl           = req.write_data[CTRL_WIDTH-1:0];
            wctrl[UNF_POS]  = wctrl[UNF_POS] & ctrl[c][UNF_POS];
            wctrl[ICPF_POS] = wctrl[ICPF_POS] & ctrl[c][ICPF_POS];
            if (wctrl[SEL_MSB:SEL_LSB] != ctrl[c][SEL_MSB:SEL_LSB]) acc_next[c] = '0;
            ctrl_next[c] = wctrl;
          end
          if (32'(req.reg_select) == 32'(REG_COUNT_BASE + c)) begin
            count_next[c] = req.write_data[COUNT_WIDTH-1:0];
          end
          if (32'(req.reg_select) == 32'(REG_RELOAD_BASE + c)) begin
            reload_next[c] = req.write_data[COUNT_WIDTH-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    // Build the result from the post-transaction state
    rsp_next           = '0;
    rsp_next.read_data = rd;
    for (int c = 0; c < OUT_CH; c++) begin
      rsp_next.irq_lines[c]       = ctrl_next[c][UNF_POS] & ctrl_next[c][UNIE_POS];
      rsp_next.underflow_pulse[c] = pulse[c];
    end
  end

  // Commit state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ctrl[c]   <= '0;
        count[c]  <= '0;
        reload[c] <= '0;
        acc[c]    <= '0;
      end
    end else if (req_fire) begin
      start <= start_next;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ctrl[c]   <= ctrl_next[c];
        count[c]  <= count_next[c];
        reload[c] <= reload_next[c];
        acc[c]    <= acc_next[c];
      end
    end
  end

  // Hold the result until the response side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  // Reads and writes never report an underflow
  a_pulse_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.kind != KIND_TICK |=> rsp.underflow_pulse == '0)
    else $error("underflow pulse on a non-tick transaction");

  // Only a tick can set channel 0's underflow flag
  a_unf_set_by_tick: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.kind != KIND_TICK && !ctrl[0][UNF_POS] |=> !ctrl[0][UNF_POS])
    else $error("underflow flag set outside a tick");

  // A stopped channel 0 keeps its prescaler across ticks
  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.kind == KIND_TICK && !start[0] |=> $stable(acc[0]))
    else $error("stopped channel prescaler moved");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for three_channel_reload_timer: an internal timer model
// predicts every response from directed and random tick, read and write traffic.
// Depends on tcrt_pkg and the three_channel_reload_timer RTL.
module tb_top;
  import tcrt_pkg::*;

  localparam int         NCH             = 3;
  localparam logic [3:0] REG_CTRL0       = 4'(REG_CTRL_BASE);
  localparam logic [3:0] REG_COUNT_BASE  = 4'(REG_CTRL_BASE + NCH);
  localparam logic [3:0] REG_RELOAD_BASE = 4'(REG_CTRL_BASE + 2 * NCH);
  localparam logic [3:0] REG_LAST        = 4'(REG_CTRL_BASE + 3 * NCH - 1);
  localparam logic [3:0] REG_TOP         = 4'd15;
  localparam logic [1:0] KIND_NONE       = 2'd3;

  // Prescaler select codes
  localparam logic [2:0] PSC_DIV4    = 3'd0;
  localparam logic [2:0] PSC_DIV16   = 3'd1;
  localparam logic [2:0] PSC_DIV64   = 3'd2;
  localparam logic [2:0] PSC_DIV256  = 3'd3;
  localparam logic [2:0] PSC_DIV1024 = 3'd4;
  localparam logic [2:0] PSC_OFF5    = 3'd5;
  localparam logic [2:0] PSC_OFF7    = 3'd7;

  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    req_t item;
    logic drain;
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  pend_t pend_q[$];
  rsp_t  timer_rsp_q[$];

  // Timer model state, cleared as after reset
  logic [2:0]  run_bits = '0;
  logic [15:0] ctl_reg [NCH] = '{default: '0};
  logic [31:0] cnt_reg [NCH] = '{default: '0};
  logic [31:0] rld_reg [NCH] = '{default: '0};
  logic [9:0]  psc_acc [NCH] = '{default: '0};

  int errors = 0;
  int n_tick = 0, n_read = 0, n_write = 0, n_other = 0;
  int n_rsp = 0, n_unf = 0;
  int send_gap = 0, recv_stall = 0, idle_cycles = 0;
  logic send_calm = 1'b0, recv_calm = 1'b0;

  three_channel_reload_timer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  function automatic logic [10:0] psc_divisor(logic [2:0] sel);
    case (sel)
      PSC_DIV4:    return 11'd4;
      PSC_DIV16:   return 11'd16;
      PSC_DIV64:   return 11'd64;
      PSC_DIV256:  return 11'd256;
      PSC_DIV1024: return 11'd1024;
      default:     return 11'd0;
    endcase
  endfunction

  // Apply one transaction to the timer model and return its response
  function automatic rsp_t timer_predict(req_t r);
    rsp_t        res;
    logic [10:0] div;
    logic [2:0]  flip;
    logic [15:0] nv;
    logic [3:0]  s;
    int          ch;
    res = '0;
    s = r.reg_select;
    case (r.kind)
      KIND_TICK: begin
        for (ch = 0; ch < NCH; ch++) begin
          div = psc_divisor(ctl_reg[ch][SEL_MSB:SEL_LSB]);
          if (run_bits[ch] && div != 0) begin
            if (11'(psc_acc[ch]) + 11'd1 >= div) begin
              psc_acc[ch] = '0;
              if (cnt_reg[ch] == 0) begin
                cnt_reg[ch] = rld_reg[ch];
                ctl_reg[ch][UNF_POS] = 1'b1;
                res.underflow_pulse[ch] = 1'b1;
              end else begin
                cnt_reg[ch] = cnt_reg[ch] - 32'd1;
              end
            end else begin
              psc_acc[ch] = psc_acc[ch] + 10'd1;
            end
          end
        end
      end
      KIND_READ: begin
        if (s == REG_OUTCTL) res.read_data = 32'd1;
        else if (s == REG_START) res.read_data = {29'b0, run_bits};
        else if (s >= REG_CTRL0 && s < REG_COUNT_BASE)
          res.read_data = {16'b0, ctl_reg[s - REG_CTRL0]};
        else if (s >= REG_COUNT_BASE && s < REG_RELOAD_BASE)
          res.read_data = cnt_reg[s - REG_COUNT_BASE];
        else if (s >= REG_RELOAD_BASE && s <= REG_LAST)
          res.read_data = rld_reg[s - REG_RELOAD_BASE];
      end
      KIND_WRITE: begin
        if (s == REG_START) begin
          flip = r.write_data[2:0] ^ run_bits;
          for (ch = 0; ch < NCH; ch++)
            if (flip[ch]) psc_acc[ch] = '0;
          run_bits = r.write_data[2:0];
        end else if (s >= REG_CTRL0 && s < REG_COUNT_BASE) begin
          ch = int'(s - REG_CTRL0);
          nv = r.write_data[15:0];
          // Flags can only be cleared by a write
          nv[UNF_POS]  = nv[UNF_POS] & ctl_reg[ch][UNF_POS];
          nv[ICPF_POS] = nv[ICPF_POS] & ctl_reg[ch][ICPF_POS];
          if (nv[SEL_MSB:SEL_LSB] != ctl_reg[ch][SEL_MSB:SEL_LSB]) psc_acc[ch] = '0;
          ctl_reg[ch] = nv;
        end else if (s >= REG_COUNT_BASE && s < REG_RELOAD_BASE) begin
          cnt_reg[s - REG_COUNT_BASE] = r.write_data;
        end else if (s >= REG_RELOAD_BASE && s <= REG_LAST) begin
          rld_reg[s - REG_RELOAD_BASE] = r.write_data;
        end
      end
      default: ;
    endcase
    for (ch = 0; ch < NCH; ch++)
      res.irq_lines[ch] = ctl_reg[ch][UNF_POS] & ctl_reg[ch][UNIE_POS];
    return res;
  endfunction

  // Mostly short gaps, some medium, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly tiny counts so underflows happen often
  function automatic logic [31:0] count_value();
    if ($urandom_range(0, 99) < 85) return 32'($urandom_range(0, 6));
    return $urandom();
  endfunction

  function automatic logic [31:0] ctrl_value();
    logic [31:0] v;
    int          r;
    v = $urandom();
    r = $urandom_range(0, 99);
    if (r < 70) v[SEL_MSB:SEL_LSB] = PSC_DIV4;
    else if (r < 85) v[SEL_MSB:SEL_LSB] = PSC_DIV16;
    else if (r < 95) v[SEL_MSB:SEL_LSB] = 3'($urandom_range(PSC_OFF5, PSC_OFF7));
    else v[SEL_MSB:SEL_LSB] = 3'($urandom_range(PSC_DIV64, PSC_DIV1024));
    return v;
  endfunction

  task automatic add_item(logic [1:0] k, logic [3:0] s, logic [31:0] d, logic drain = 1'b0);
    pend_t p;
    p.item.kind       = k;
    p.item.reg_select = s;
    p.item.write_data = d;
    p.drain           = drain;
    pend_q.push_back(p);
  endtask

  task automatic report_err(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // Driver: present queued transactions with random gaps
  always @(posedge clk) begin : drive_proc
    logic nxt_valid;
    req_t nxt_req;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      nxt_valid = req_valid;
      nxt_req   = req;
      if (req_valid && req_ready) begin
        timer_rsp_q.push_back(timer_predict(req));
        case (req.kind)
          KIND_TICK:  n_tick++;
          KIND_READ:  n_read++;
          KIND_WRITE: n_write++;
          default:    n_other++;
        endcase
        nxt_valid = 1'b0;
        if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : pick_gap();
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pend_q.size() > 0 && !(pend_q[0].drain && timer_rsp_q.size() != 0)) begin
          nxt_req   = pend_q[0].item;
          nxt_valid = 1'b1;
          pend_q.pop_front();
        end
      end
      req_valid <= nxt_valid;
      req       <= nxt_req;
    end
  end

  // Monitor: check each response against the oldest prediction, stall at random
  always @(posedge clk) begin : check_proc
    rsp_t want;
    logic nxt_ready;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        n_rsp++;
        if (rsp.underflow_pulse != 0) n_unf++;
        if (timer_rsp_q.size() == 0) begin
          report_err("unexpected response", 32'(rsp), '0);
        end else begin
          want = timer_rsp_q.pop_front();
          if (rsp.read_data !== want.read_data)
            report_err("read_data", rsp.read_data, want.read_data);
          if (rsp.irq_lines !== want.irq_lines)
            report_err("irq_lines", 32'(rsp.irq_lines), 32'(want.irq_lines));
          if (rsp.underflow_pulse !== want.underflow_pulse)
            report_err("underflow_pulse", 32'(rsp.underflow_pulse),
                       32'(want.underflow_pulse));
        end
      end
      if ($urandom_range(0, 299) == 0) recv_calm = !recv_calm;
      if (recv_stall > 0) begin
        recv_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if (!recv_calm && $urandom_range(0, 99) < 15) recv_stall = pick_gap();
      end
      rsp_ready <= nxt_ready;
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
          $display("[three_channel_reload_timer] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stim_proc
    int target, roll, ch, k, total;

    // Directed: register map edges, flags, select and start changes
    add_item(KIND_READ, REG_OUTCTL, '0);
    add_item(KIND_WRITE, REG_OUTCTL, 32'hFFFF_FFFF);
    add_item(KIND_READ, REG_OUTCTL, '0);
    add_item(KIND_WRITE, REG_RELOAD_BASE, 32'hFFFF_FFFF);
    add_item(KIND_WRITE, REG_COUNT_BASE, 32'h0);
    add_item(KIND_WRITE, REG_CTRL0, 32'hFFFF_FFFF);      // unused select, flags stay clear
    add_item(KIND_WRITE, REG_START, 32'hFFFF_FFFF);      // upper start bits dropped
    add_item(KIND_TICK, REG_OUTCTL, 32'hFFFF_FFFF);
    add_item(KIND_WRITE, REG_CTRL0, 32'h0000_0020);      // divide by 4, interrupt on
    for (k = 0; k < 4; k++) add_item(KIND_TICK, 4'($urandom_range(0, 15)), $urandom());
    add_item(KIND_READ, REG_CTRL0, '0);
    add_item(KIND_READ, REG_COUNT_BASE, '0);
    add_item(KIND_WRITE, REG_CTRL0, 32'h0000_0321);      // flags cannot be set by a write
    add_item(KIND_WRITE, REG_CTRL0, 32'h0000_FEFF);      // clear the underflow flag
    add_item(KIND_READ, REG_CTRL0, '0);
    add_item(KIND_WRITE, REG_START, 32'h0000_0005);
    add_item(KIND_READ, REG_START, '0);
    add_item(KIND_READ, REG_TOP, '0);
    add_item(KIND_WRITE, REG_LAST + 4'd1, 32'hFFFF_FFFF);
    add_item(KIND_NONE, REG_START, 32'h0000_0000);
    add_item(KIND_READ, REG_LAST, '0);
    add_item(KIND_READ, REG_COUNT_BASE + 4'd1, '0, 1'b1);

    // Random: channel setups, tick bursts, reads, flag clears and noise
    target = pend_q.size() + RANDOM_ITEMS;
    while (pend_q.size() < target) begin
      roll = $urandom_range(0, 99);
      ch = $urandom_range(0, NCH - 1);
      if (roll < 12) begin
        add_item(KIND_WRITE, REG_RELOAD_BASE + 4'(ch), count_value(),
                 $urandom_range(0, 11) == 0);
        add_item(KIND_WRITE, REG_COUNT_BASE + 4'(ch), count_value());
        add_item(KIND_WRITE, REG_CTRL0 + 4'(ch), ctrl_value());
        add_item(KIND_WRITE, REG_START, $urandom_range(0, 3) == 0 ? $urandom() : 32'h7);
      end else if (roll < 55) begin
        for (k = $urandom_range(1, 12); k > 0; k--)
          add_item(KIND_TICK, 4'($urandom_range(0, 15)), $urandom());
      end else if (roll < 75) begin
        add_item(KIND_READ, 4'($urandom_range(0, $urandom_range(0, 9) == 0 ? 15 : 10)),
                 $urandom());
      end else if (roll < 87) begin
        add_item(KIND_WRITE, REG_CTRL0 + 4'(ch), ctrl_value() & ~(32'h1 << UNF_POS));
      end else if (roll < 93) begin
        add_item(KIND_WRITE, REG_START, $urandom());
      end else begin
        add_item(2'($urandom_range(KIND_TICK, KIND_WRITE)), 4'($urandom_range(0, 15)),
                 $urandom());
      end
    end
    total = pend_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait until every queued transaction has been answered
    while (n_rsp < total) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions: %0d ticks, %0d reads, %0d writes, %0d unknown",
             n_tick + n_read + n_write + n_other, n_tick, n_read, n_write, n_other);
    $display("Checked %0d responses, %0d carrying underflow pulses; %0d mismatches",
             n_rsp, n_unf, errors);
    if (errors == 0) begin
      $display("[three_channel_reload_timer] OK");
    end else begin
      $display("[three_channel_reload_timer] ERROR");
    end
    $finish;
  end

endmodule
